### rtl/sthm_pkg.sv
// Shared types and constants for the threshold monitor with hysteresis.
package sthm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CMP_MAX     = 8;   // two comparators for each of up to four thresholds
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] PERIOD_RESET = 16'd60;
  localparam int          COUNTS_PER_DEGREE_LOG2 = 4;
  // 16 counts a degree minus the quarter-degree offset of four counts
  localparam logic signed [20:0] EXT_OFFSET = 21'sd12;
  localparam logic signed [20:0] SAT_MAX = 21'sd32767;
  localparam logic signed [20:0] SAT_MIN = -21'sd32768;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_PERIOD   = 3'd0,
    CFG_SENSOR_TYPE     = 3'd1,
    CFG_THRESHOLD_ZERO  = 3'd2,
    CFG_THRESHOLD_ONE   = 3'd3,
    CFG_THRESHOLD_TWO   = 3'd4,
    CFG_THRESHOLD_THREE = 3'd5,
    CFG_HYSTERESIS      = 3'd6,
    CFG_COMPARE_ENABLES = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    SENSOR_NONE     = 2'd0,
    SENSOR_DIRECT   = 2'd1,
    SENSOR_EXTENDED = 2'd2
  } sensor_type_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // One tick's worth of results, passed from the front to the back.
  typedef struct packed {
    logic                start;
    logic [CMP_MAX-1:0]  mask;    // comparator k fired
    logic [CMP_MAX-1:0]  enter;   // flag value after the tick: 1 entered, 0 left
    logic signed [15:0]  value;
  } job_t;

endpackage

### rtl/sensor_threshold_hysteresis_monitor.sv
// Top level of the single-channel threshold monitor with hysteresis.
//
//  channel  direction  handshake                  payload
//  sample   in         sample_valid/sample_stall  tick, present, raw_reading, count_remain
//  event    out        event_valid/event_stall    kind, threshold_index, high_side,
//                                                 entered, current_value, last
//  config   in         cfg_write                  cfg_index, cfg_data
//
// The front takes one sample every cycle while the two-entry queue has room.
// Each tick with results hands the back one request per result (1 to 8), sent
// through its single result register; ticks without results push nothing.
// rst clears countdown, reading, alarm flags, queue and result valid; registers
// return to their reset values. No clearing pass follows reset.
// A stalled event holds its payload; the front keeps working until the queue fills.
module sensor_threshold_hysteresis_monitor
  import sthm_pkg::*;
#(
  parameter int THRESHOLD_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic                   tick,
  input  logic                   present,
  input  logic signed [15:0]     raw_reading,
  input  logic [7:0]             count_remain,
  output logic                   event_valid,
  input  logic                   event_stall,
  output logic                   kind,
  output logic [1:0]             threshold_index,
  output logic                   high_side,
  output logic                   entered,
  output logic signed [15:0]     current_value,
  output logic                   last
);

  logic push;
  logic queue_ready;
  job_t push_job;
  logic pop;
  logic avail;
  job_t pop_job;

  sthm_front #(
    .THRESHOLD_COUNT (THRESHOLD_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .tick         (tick),
    .present      (present),
    .raw_reading  (raw_reading),
    .count_remain (count_remain),
    .queue_ready  (queue_ready),
    .push         (push),
    .job          (push_job)
  );

  sthm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .ready    (queue_ready),
    .pop      (pop),
    .avail    (avail),
    .pop_job  (pop_job)
  );

  sthm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .avail           (avail),
    .pop_job         (pop_job),
    .pop             (pop),
    .event_valid     (event_valid),
    .event_stall     (event_stall),
    .kind            (kind),
    .threshold_index (threshold_index),
    .high_side       (high_side),
    .entered         (entered),
    .current_value   (current_value),
    .last            (last)
  );

endmodule

### rtl/sthm_front.sv
// Front: configuration registers, countdown, conversion and comparator evaluation.
module sthm_front
  import sthm_pkg::*;
#(
  parameter int THRESHOLD_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic                   tick,
  input  logic                   present,
  input  logic signed [15:0]     raw_reading,
  input  logic [7:0]             count_remain,
  input  logic                   queue_ready,
  output logic                   push,
  output job_t                   job
);

  localparam int FLAG_W = 2 * THRESHOLD_COUNT;

  logic [15:0]         sample_period;
  sensor_type_t        sensor_type;
  logic signed [15:0]  threshold [THRESHOLD_COUNT];
  logic [31:0]         hysteresis_bytes;
  logic [7:0]          compare_enables;

  logic [15:0]         countdown;
  logic [15:0]         countdown_next;
  logic signed [15:0]  reading;
  logic signed [15:0]  reading_next;
  logic [FLAG_W-1:0]   alarm_flags;
  logic [FLAG_W-1:0]   alarm_flags_next;
  logic [FLAG_W-1:0]   fired;

  logic                accept;
  logic [15:0]         cd_dec;
  logic                start;
  logic                sample;
  logic signed [15:0]  half;
  logic signed [20:0]  ext_wide;
  logic signed [15:0]  ext_value;
  logic signed [17:0]  val18;

  assign sample_stall = !queue_ready;
  assign accept       = sample_valid && queue_ready && tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period    <= PERIOD_RESET;
      sensor_type      <= SENSOR_NONE;
      hysteresis_bytes <= '0;
      compare_enables  <= '0;
      for (int j = 0; j < THRESHOLD_COUNT; j++) begin
        threshold[j] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD:   sample_period    <= cfg_data[15:0];
        CFG_SENSOR_TYPE:     sensor_type      <= sensor_type_t'(cfg_data[1:0]);
        CFG_HYSTERESIS:      hysteresis_bytes <= cfg_data;
        CFG_COMPARE_ENABLES: compare_enables  <= cfg_data[7:0];
        default: begin
          for (int j = 0; j < THRESHOLD_COUNT; j++) begin
            if (cfg_index == CFG_INDEX_W'(CFG_THRESHOLD_ZERO + j)) begin
              threshold[j] <= cfg_data[15:0];
            end
          end
        end
      endcase
    end
  end

  // Extended-resolution conversion: floor(raw/2)*16 + 12 - count_remain, saturated.
  always_comb begin
    half     = raw_reading >>> 1;
    ext_wide = (21'(half) <<< COUNTS_PER_DEGREE_LOG2) + EXT_OFFSET
               - 21'(signed'({1'b0, count_remain}));
    if (ext_wide > SAT_MAX) begin
      ext_value = 16'sh7fff;
    end else if (ext_wide < SAT_MIN) begin
      ext_value = 16'sh8000;
    end else begin
      ext_value = ext_wide[15:0];
    end
  end

  always_comb begin
    cd_dec = (countdown != 16'd0) ? countdown - 16'd1 : 16'd0;
    sample = (cd_dec == 16'd0);
    start  = (cd_dec == 16'd1) && present &&
             (sensor_type == SENSOR_DIRECT || sensor_type == SENSOR_EXTENDED);
    reading_next = reading;
    if (sample && present) begin
      case (sensor_type)
        SENSOR_DIRECT:   reading_next = raw_reading;
        SENSOR_EXTENDED: reading_next = ext_value;
        default:         reading_next = reading;
      endcase
    end
    countdown_next = sample ? sample_period : cd_dec;
  end

  // Each comparator fires at most once a tick: enter and leave need disjoint ranges.
  always_comb begin
    logic signed [17:0] lvl18;
    logic signed [17:0] upper;
    logic signed [17:0] lower;
    logic signed [17:0] hy18;
    val18            = 18'(reading_next);
    alarm_flags_next = alarm_flags;
    fired            = '0;
    for (int j = 0; j < THRESHOLD_COUNT; j++) begin
      lvl18 = 18'(threshold[j]);
      hy18  = signed'({10'd0, hysteresis_bytes[8*j +: 8]});
      upper = lvl18 + hy18;
      lower = lvl18 - hy18;
      if (sample && compare_enables[2*j]) begin
        if (val18 < lvl18 && !alarm_flags[2*j]) begin
          alarm_flags_next[2*j] = 1'b1;
          fired[2*j]            = 1'b1;
        end else if (val18 >= upper && alarm_flags[2*j]) begin
          alarm_flags_next[2*j] = 1'b0;
          fired[2*j]            = 1'b1;
        end
      end
      if (sample && compare_enables[2*j+1]) begin
        if (val18 > lvl18 && !alarm_flags[2*j+1]) begin
          alarm_flags_next[2*j+1] = 1'b1;
          fired[2*j+1]            = 1'b1;
        end else if (val18 <= lower && alarm_flags[2*j+1]) begin
          alarm_flags_next[2*j+1] = 1'b0;
          fired[2*j+1]            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown   <= '0;
      reading     <= '0;
      alarm_flags <= '0;
    end else if (accept) begin
      countdown   <= countdown_next;
      reading     <= reading_next;
      alarm_flags <= alarm_flags_next;
    end
  end

  always_comb begin
    push      = accept && (start || (fired != '0));
    job.start = start;
    job.mask  = CMP_MAX'(fired);
    job.enter = CMP_MAX'(alarm_flags_next);
    job.value = reading_next;
  end

endmodule

### rtl/sthm_queue.sv
// Two-entry queue of result sets between front and back.
module sthm_queue
  import sthm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic ready,
  input  logic pop,
  output logic avail,
  output job_t pop_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign ready   = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign pop_job = entries[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    !ready |=> !(do_push && $past(count) == count && !$past(do_pop)) || avail)
    else $error("queue accepted a push while full");

  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

### rtl/sthm_back.sv
// Back: walks one result set and drives the result register, one request a cycle while the event output is not stalled.
module sthm_back
  import sthm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  job_t               pop_job,
  output logic               pop,
  output logic               event_valid,
  input  logic               event_stall,
  output logic               kind,
  output logic [1:0]         threshold_index,
  output logic               high_side,
  output logic               entered,
  output logic signed [15:0] current_value,
  output logic               last
);

  localparam int PICK_W = $clog2(CMP_MAX);

  logic               cur_valid;
  job_t               cur;
  logic [PICK_W-1:0]  pick;
  logic [CMP_MAX-1:0] rem;
  logic               out_free;
  logic               emit;
  logic               emit_last;

  always_comb begin
    pick = '0;
    for (int k = CMP_MAX - 1; k >= 0; k--) begin
      if (cur.mask[k]) pick = PICK_W'(k);
    end
    rem       = cur.mask & (cur.mask - 1'b1);
    out_free  = !event_valid || !event_stall;
    emit      = cur_valid && out_free;
    emit_last = cur.start ? (cur.mask == '0) : (rem == '0);
    pop       = avail && (!cur_valid || (emit && emit_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (emit && emit_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_job;
    end else if (emit) begin
      // drop the request just sent
      if (cur.start) cur.start <= 1'b0;
      else           cur.mask  <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_free) begin
      event_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      current_value <= cur.value;
      last          <= emit_last;
      if (cur.start) begin
        kind            <= KIND_START;
        threshold_index <= '0;
        high_side       <= 1'b0;
        entered         <= 1'b0;
      end else begin
        kind            <= KIND_EVENT;
        threshold_index <= pick[PICK_W-1:1];
        high_side       <= pick[0];
        entered         <= cur.enter[pick];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (event_valid && kind == KIND_START) |->
      (last && threshold_index == 2'd0 && !high_side && !entered))
    else $error("start request not alone or carries event fields");

  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.start || cur.mask != '0))
    else $error("empty result set held in back");

  assert property (@(posedge clk)
    rst |=> !event_valid && !cur_valid)
    else $error("back not idle after reset");

endmodule
